/* rtl/rvx_pkg.sv */
`default_nettype none

package rvx_pkg;

    localparam int DATA_W = 32;
    localparam int PC_W   = 16;

    localparam logic [3:0] SP_INDEX_RESET = 4'd14;
    localparam logic [3:0] FP_INDEX_RESET = 4'd15;

    localparam logic REG_SP_INDEX = 1'b0;
    localparam logic REG_FP_INDEX = 1'b1;

    typedef enum logic [4:0] {
        OP_ADD      = 5'd0,
        OP_SUB      = 5'd1,
        OP_MULT     = 5'd2,
        OP_DIV      = 5'd3,
        OP_MOD      = 5'd4,
        OP_LT       = 5'd5,
        OP_LTEQ     = 5'd6,
        OP_EQ       = 5'd7,
        OP_AND      = 5'd8,
        OP_OR       = 5'd9,
        OP_MOVE     = 5'd10,
        OP_LOAD_IMM = 5'd11,
        OP_BEGIN    = 5'd12,
        OP_NOOP     = 5'd13,
        OP_END      = 5'd14,
        OP_JUMP     = 5'd15,
        OP_BNZ      = 5'd16,
        OP_BZ       = 5'd17,
        OP_JUMP_IND = 5'd18,
        OP_PUSH     = 5'd19,
        OP_POP      = 5'd20,
        OP_CALL     = 5'd21,
        OP_STACK_WR = 5'd22,
        OP_STACK_RD = 5'd23,
        OP_HEAP_WR  = 5'd24,
        OP_HEAP_RD  = 5'd25,
        OP_INC      = 5'd26
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDSP,
        S_ADDR,
        S_PREP,
        S_MODQ,
        S_MODR,
        S_MODW,
        S_DIVW,
        S_MEM,
        S_EXEC,
        S_WB2,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

/* rtl/register_vm_execute_unit.sv */
// Execute unit of a small register machine: one decoded instruction per transfer.
// Configuration goes through an APB-style port: the stack pointer register number at
// byte address 0 and the frame pointer register number at byte address 4. Write it
// only while the unit is idle.
// The input channel (in_valid, in_stall) carries one instruction per transfer. The
// output channel (out_valid, out_stall) returns one result per instruction: the next
// instruction index, the halt status, the register write and the divide-by-zero flag.
// The unit takes a new input transfer only once the previous instruction has left for
// the output register. The register file and the stack and heap memories are
// synchronous memories with registered read data; the sequencer steps through register
// read, stack pointer read, address, prepare, memory, execute and two register write
// steps. Div and mod with a nonzero divisor pass through a one-bit-per-cycle divider
// before the memory step. When a memory depth is not a power of two, the address is
// reduced by a reciprocal multiply, a remainder and a correction before the memory step.
// A finished result waits in the output register while the receiver stalls, and the
// next instruction is taken in the meantime; it completes its result only once that
// register is free.
// Reset clears the program counter, the halt status and the register file (all
// registers read as zero) and restores the pointer register numbers to 14 and 15.
// Stack and heap contents are undefined until written.
`default_nettype none

module register_vm_execute_unit
    import rvx_pkg::*;
#(
    parameter int NUM_REGS    = 16,
    parameter int STACK_DEPTH = 1024,
    parameter int HEAP_DEPTH  = 1024
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [4:0]         kind,
    input  wire logic [3:0]         dest,
    input  wire logic [3:0]         src_a,
    input  wire logic [3:0]         src_b,
    input  wire logic signed [15:0] offset,
    input  wire logic signed [31:0] immediate,
    input  wire logic [15:0]        target,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [15:0]             next_pc,
    output logic                    halted,
    output logic                    wrote_reg,
    output logic [3:0]              write_index,
    output logic signed [31:0]      write_value,
    output logic                    div_by_zero
);

    localparam int  RW      = $clog2(NUM_REGS);
    localparam int  SAW     = $clog2(STACK_DEPTH);
    localparam int  HAW     = $clog2(HEAP_DEPTH);
    localparam bit  S_POW2  = (STACK_DEPTH & (STACK_DEPTH - 1)) == 0;
    localparam bit  H_POW2  = (HEAP_DEPTH & (HEAP_DEPTH - 1)) == 0;
    localparam logic [DATA_W-1:0] S_RECIP = DATA_W'((64'd1 << 32) / 64'(STACK_DEPTH));
    localparam logic [DATA_W-1:0] H_RECIP = DATA_W'((64'd1 << 32) / 64'(HEAP_DEPTH));

    function automatic logic [RW-1:0] rmod(input logic [3:0] r);
        logic [6:0] v;
        v = {3'b000, r};
        for (int i = 0; i < 4; i++)
        begin
            if (v >= 7'(NUM_REGS))
            begin
                v = v - 7'(NUM_REGS);
            end
        end
        return v[RW-1:0];
    endfunction

    state_t state_reg;
    state_t state_next;

    logic [3:0] sp_cfg_reg;
    logic [3:0] fp_cfg_reg;
    logic [RW-1:0] sp_i;
    logic [RW-1:0] fp_i;

    op_t                 kind_reg;
    logic [RW-1:0]       d_reg;
    logic [RW-1:0]       a_reg;
    logic [15:0]         off_reg;
    logic [DATA_W-1:0]   imm_reg;
    logic [PC_W-1:0]     tgt_reg;
    logic [DATA_W-1:0]   va_reg;
    logic [DATA_W-1:0]   vb_reg;
    logic [DATA_W-1:0]   spv_reg;
    logic [DATA_W-1:0]   maddr_reg;
    logic [SAW-1:0]      sidx_reg;
    logic [HAW-1:0]      hidx_reg;
    logic [DATA_W-1:0]   sdata_reg;
    logic [DATA_W-1:0]   hdata_reg;
    logic [PC_W-1:0]     pc_reg;
    logic                halt_reg;

    logic [DATA_W-1:0]   rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] rf_valid_reg;
    logic [DATA_W-1:0]   rd0_raw_reg;
    logic [DATA_W-1:0]   rd1_raw_reg;
    logic                rd0_ok_reg;
    logic                rd1_ok_reg;
    logic [DATA_W-1:0]   rd0;
    logic [DATA_W-1:0]   rd1;
    logic [RW-1:0]       rf_ra0;
    logic [RW-1:0]       rf_ra1;
    logic                rf_we;
    logic [RW-1:0]       rf_wa;
    logic [DATA_W-1:0]   rf_wd;

    logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0]   heap_mem [HEAP_DEPTH];

    logic                w2_en_reg;
    logic [RW-1:0]       w2_idx_reg;
    logic [DATA_W-1:0]   w2_val_reg;

    logic [PC_W-1:0]     res_pc_reg;
    logic                res_halt_reg;
    logic                res_wrote_reg;
    logic [RW-1:0]       res_idx_reg;
    logic [DATA_W-1:0]   res_val_reg;
    logic                res_dz_reg;

    logic                out_valid_reg;
    logic [PC_W-1:0]     out_pc_reg;
    logic                out_halt_reg;
    logic                out_wrote_reg;
    logic [RW-1:0]       out_idx_reg;
    logic [DATA_W-1:0]   out_val_reg;
    logic                out_dz_reg;
    logic [6:0]          out_idx_ext;

    logic                accept;
    logic                out_load;
    logic                uses_mem;
    logic                is_heap;
    logic                is_divmod;
    logic                need_mod;
    logic                need_div;
    logic                div_start;
    logic                div_done;
    logic [DATA_W-1:0]   div_quo;
    logic [DATA_W-1:0]   div_rem;
    logic [DATA_W-1:0]   div_dividend;
    logic [DATA_W-1:0]   div_divisor;
    logic [DATA_W-1:0]   abs_a;
    logic [DATA_W-1:0]   abs_b;
    logic [DATA_W-1:0]   maddr_raw;
    logic [PC_W-1:0]     pc_inc;
    logic                stack_we;
    logic [DATA_W-1:0]   stack_wd;
    logic                heap_we;

    logic [DATA_W-1:0]   mod_d;
    logic [DATA_W-1:0]   mod_recip;
    logic [2*DATA_W-1:0] mod_prod;
    logic [DATA_W-1:0]   mod_q_reg;
    logic [DATA_W-1:0]   mod_r_reg;
    logic [DATA_W-1:0]   mod_fix;

    logic                ex_w1_en;
    logic [RW-1:0]       ex_w1_idx;
    logic [DATA_W-1:0]   ex_w1_val;
    logic                ex_w2_en;
    logic [RW-1:0]       ex_w2_idx;
    logic [DATA_W-1:0]   ex_w2_val;
    logic                ex_wrote;
    logic [RW-1:0]       ex_widx;
    logic [DATA_W-1:0]   ex_wval;
    logic                ex_dz;
    logic [PC_W-1:0]     ex_nxt;
    logic                ex_halt;
    logic [DATA_W-1:0]   q_fix;
    logic [DATA_W-1:0]   r_fix;

    // Configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_cfg_reg <= SP_INDEX_RESET;
            fp_cfg_reg <= FP_INDEX_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_SP_INDEX: sp_cfg_reg <= pwdata[3:0];
                REG_FP_INDEX: fp_cfg_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_FP_INDEX: prdata = {28'd0, fp_cfg_reg};
            default:      prdata = {28'd0, sp_cfg_reg};
        endcase
    end

    assign pready = 1'b1;
    assign sp_i   = rmod(sp_cfg_reg);
    assign fp_i   = rmod(fp_cfg_reg);

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // Register file: two read ports, one write port, per-entry valid bits.
    assign rf_ra0 = (state_reg == S_IDLE) ? rmod(src_a) : sp_i;
    assign rf_ra1 = rmod(src_b);
    assign rd0    = rd0_ok_reg ? rd0_raw_reg : '0;
    assign rd1    = rd1_ok_reg ? rd1_raw_reg : '0;

    assign rf_we = ((state_reg == S_EXEC) && ex_w1_en) || ((state_reg == S_WB2) && w2_en_reg);
    assign rf_wa = (state_reg == S_EXEC) ? ex_w1_idx : w2_idx_reg;
    assign rf_wd = (state_reg == S_EXEC) ? ex_w1_val : w2_val_reg;

    always_ff @(posedge clk)
    begin
        rd0_raw_reg <= rf_mem[rf_ra0];
        rd1_raw_reg <= rf_mem[rf_ra1];
        if (rf_we)
        begin
            rf_mem[rf_wa] <= rf_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
            rd0_ok_reg   <= 1'b0;
            rd1_ok_reg   <= 1'b0;
        end
        else
        begin
            rd0_ok_reg <= rf_valid_reg[rf_ra0];
            rd1_ok_reg <= rf_valid_reg[rf_ra1];
            if (rf_we)
            begin
                rf_valid_reg[rf_wa] <= 1'b1;
            end
        end
    end

    // Instruction classes.
    assign is_heap   = (kind_reg == OP_HEAP_WR) || (kind_reg == OP_HEAP_RD);
    assign uses_mem  = (kind_reg == OP_PUSH) || (kind_reg == OP_POP) || (kind_reg == OP_CALL)
                    || (kind_reg == OP_STACK_WR) || (kind_reg == OP_STACK_RD) || is_heap;
    assign is_divmod = (kind_reg == OP_DIV) || (kind_reg == OP_MOD);
    assign need_mod  = !halt_reg && uses_mem && !(is_heap ? H_POW2 : S_POW2);
    assign need_div  = !halt_reg && is_divmod && (vb_reg != '0);
    assign div_start = (state_reg == S_PREP) && need_div;

    assign abs_a = va_reg[DATA_W-1] ? (-va_reg) : va_reg;
    assign abs_b = vb_reg[DATA_W-1] ? (-vb_reg) : vb_reg;
    assign div_dividend = abs_a;
    assign div_divisor  = abs_b;

    rvx_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign q_fix = (va_reg[DATA_W-1] ^ vb_reg[DATA_W-1]) ? (-div_quo) : div_quo;
    assign r_fix = va_reg[DATA_W-1] ? (-div_rem) : div_rem;

    // The estimated quotient is at most one below the true one, so one correction suffices.
    assign mod_d     = is_heap ? DATA_W'(HEAP_DEPTH) : DATA_W'(STACK_DEPTH);
    assign mod_recip = is_heap ? H_RECIP : S_RECIP;
    assign mod_prod  = {{DATA_W{1'b0}}, maddr_reg} * {{DATA_W{1'b0}}, mod_recip};
    assign mod_fix   = (mod_r_reg >= mod_d) ? (mod_r_reg - mod_d) : mod_r_reg;

    always_comb
    begin
        case (kind_reg)
            OP_PUSH, OP_CALL: maddr_raw = rd0;
            OP_POP:           maddr_raw = rd0 - DATA_W'(1);
            default:          maddr_raw = vb_reg + {{(DATA_W-16){off_reg[15]}}, off_reg};
        endcase
    end

    // Stack and heap memories.
    assign pc_inc   = pc_reg + PC_W'(1);
    assign stack_we = !halt_reg && ((kind_reg == OP_PUSH) || (kind_reg == OP_CALL)
                   || (kind_reg == OP_STACK_WR));
    assign stack_wd = (kind_reg == OP_CALL) ? {{(DATA_W-PC_W){1'b0}}, pc_inc} : va_reg;
    assign heap_we  = !halt_reg && (kind_reg == OP_HEAP_WR);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MEM)
        begin
            sdata_reg <= stack_mem[sidx_reg];
            hdata_reg <= heap_mem[hidx_reg];
            if (stack_we)
            begin
                stack_mem[sidx_reg] <= stack_wd;
            end
            if (heap_we)
            begin
                heap_mem[hidx_reg] <= va_reg;
            end
        end
    end

    // Execute.
    always_comb
    begin
        ex_w1_en  = 1'b0;
        ex_w1_idx = d_reg;
        ex_w1_val = '0;
        ex_w2_en  = 1'b0;
        ex_w2_idx = sp_i;
        ex_w2_val = '0;
        ex_wrote  = 1'b0;
        ex_widx   = d_reg;
        ex_wval   = '0;
        ex_dz     = 1'b0;
        ex_nxt    = pc_inc;
        ex_halt   = halt_reg;
        if (halt_reg)
        begin
            ex_nxt = pc_reg;
        end
        else
        begin
            case (kind_reg)
                OP_ADD:   begin ex_w1_en = 1'b1; ex_w1_val = va_reg + vb_reg; end
                OP_SUB:   begin ex_w1_en = 1'b1; ex_w1_val = va_reg - vb_reg; end
                OP_MULT:  begin ex_w1_en = 1'b1; ex_w1_val = va_reg * vb_reg; end
                OP_DIV:
                begin
                    ex_w1_en  = 1'b1;
                    ex_dz     = (vb_reg == '0);
                    ex_w1_val = ex_dz ? '0 : q_fix;
                end
                OP_MOD:
                begin
                    ex_w1_en  = 1'b1;
                    ex_dz     = (vb_reg == '0);
                    ex_w1_val = ex_dz ? '0 : r_fix;
                end
                OP_LT:
                begin
                    ex_w1_en  = 1'b1;
                    ex_w1_val = DATA_W'($signed(va_reg) < $signed(vb_reg));
                end
                OP_LTEQ:
                begin
                    ex_w1_en  = 1'b1;
                    ex_w1_val = DATA_W'($signed(va_reg) <= $signed(vb_reg));
                end
                OP_EQ:    begin ex_w1_en = 1'b1; ex_w1_val = DATA_W'(va_reg == vb_reg); end
                OP_AND:
                begin
                    ex_w1_en  = 1'b1;
                    ex_w1_val = DATA_W'((va_reg == DATA_W'(1)) && (vb_reg == DATA_W'(1)));
                end
                OP_OR:
                begin
                    ex_w1_en  = 1'b1;
                    ex_w1_val = DATA_W'((va_reg == DATA_W'(1)) || (vb_reg == DATA_W'(1)));
                end
                OP_MOVE:  begin ex_w1_en = 1'b1; ex_w1_val = va_reg; end
                OP_LOAD_IMM: begin ex_w1_en = 1'b1; ex_w1_val = imm_reg; end
                OP_END:   begin ex_halt = 1'b1; ex_nxt = pc_reg; end
                OP_JUMP:  ex_nxt = tgt_reg;
                OP_BNZ:   ex_nxt = (va_reg != '0) ? tgt_reg : pc_inc;
                OP_BZ:    ex_nxt = (va_reg == '0) ? tgt_reg : pc_inc;
                OP_JUMP_IND: ex_nxt = va_reg[PC_W-1:0];
                OP_PUSH:
                begin
                    ex_w1_en  = 1'b1;
                    ex_w1_idx = sp_i;
                    ex_w1_val = spv_reg + DATA_W'(1);
                end
                OP_POP:
                begin
                    ex_w1_en  = 1'b1;
                    ex_w1_val = sdata_reg;
                    ex_w2_en  = 1'b1;
                    ex_w2_val = spv_reg - DATA_W'(1);
                end
                OP_CALL:
                begin
                    ex_w1_en  = 1'b1;
                    ex_w1_idx = fp_i;
                    ex_w1_val = spv_reg;
                    ex_w2_en  = 1'b1;
                    ex_w2_val = spv_reg + DATA_W'(1);
                    ex_nxt    = tgt_reg;
                end
                OP_STACK_RD: begin ex_w1_en = 1'b1; ex_w1_val = sdata_reg; end
                OP_HEAP_RD:  begin ex_w1_en = 1'b1; ex_w1_val = hdata_reg; end
                OP_INC:
                begin
                    ex_w1_en  = 1'b1;
                    ex_w1_idx = a_reg;
                    ex_w1_val = va_reg + DATA_W'(1);
                end
                default: ;
            endcase
            ex_wrote = ex_w1_en;
            if (kind_reg == OP_PUSH || kind_reg == OP_CALL)
            begin
                ex_widx = sp_i;
            end
            else
            begin
                ex_widx = ex_w1_idx;
            end
            if (ex_w2_en && (ex_w2_idx == ex_widx))
            begin
                ex_wval = ex_w2_val;
            end
            else
            begin
                ex_wval = ex_w1_val;
            end
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_RDSP;
            S_RDSP: state_next = S_ADDR;
            S_ADDR: state_next = S_PREP;
            S_PREP:
            begin
                if (need_mod)
                begin
                    state_next = S_MODQ;
                end
                else if (need_div)
                begin
                    state_next = S_DIVW;
                end
                else
                begin
                    state_next = S_MEM;
                end
            end
            S_MODQ: state_next = S_MODR;
            S_MODR: state_next = S_MODW;
            S_MODW: state_next = S_MEM;
            S_DIVW: if (div_done) state_next = S_MEM;
            S_MEM:  state_next = S_EXEC;
            S_EXEC: state_next = S_WB2;
            S_WB2:  state_next = S_DONE;
            S_DONE: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= op_t'(kind);
            d_reg    <= rmod(dest);
            a_reg    <= rmod(src_a);
            off_reg  <= offset;
            imm_reg  <= immediate;
            tgt_reg  <= target;
        end
        if (state_reg == S_RDSP)
        begin
            va_reg <= rd0;
            vb_reg <= rd1;
        end
        if (state_reg == S_ADDR)
        begin
            spv_reg   <= rd0;
            maddr_reg <= maddr_raw;
        end
        if (state_reg == S_PREP)
        begin
            sidx_reg <= maddr_reg[SAW-1:0];
            hidx_reg <= maddr_reg[HAW-1:0];
        end
        if (state_reg == S_MODQ)
        begin
            mod_q_reg <= mod_prod[2*DATA_W-1:DATA_W];
        end
        if (state_reg == S_MODR)
        begin
            mod_r_reg <= maddr_reg - mod_q_reg * mod_d;
        end
        if (state_reg == S_MODW)
        begin
            sidx_reg <= mod_fix[SAW-1:0];
            hidx_reg <= mod_fix[HAW-1:0];
        end
        if (state_reg == S_EXEC)
        begin
            w2_en_reg     <= ex_w2_en;
            w2_idx_reg    <= ex_w2_idx;
            w2_val_reg    <= ex_w2_val;
            res_pc_reg    <= ex_nxt;
            res_halt_reg  <= ex_halt;
            res_wrote_reg <= ex_wrote;
            res_idx_reg   <= ex_wrote ? ex_widx : '0;
            res_val_reg   <= ex_wrote ? ex_wval : '0;
            res_dz_reg    <= ex_dz;
        end
        if (out_load)
        begin
            out_pc_reg    <= res_pc_reg;
            out_halt_reg  <= res_halt_reg;
            out_wrote_reg <= res_wrote_reg;
            out_idx_reg   <= res_idx_reg;
            out_val_reg   <= res_val_reg;
            out_dz_reg    <= res_dz_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_EXEC)
            begin
                pc_reg   <= ex_nxt;
                halt_reg <= ex_halt;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_idx_ext = 7'(out_idx_reg);
    assign out_valid   = out_valid_reg;
    assign next_pc     = out_pc_reg;
    assign halted      = out_halt_reg;
    assign wrote_reg   = out_wrote_reg;
    assign write_index = out_idx_ext[3:0];
    assign write_value = $signed(out_val_reg);
    assign div_by_zero = out_dz_reg;

endmodule

`default_nettype wire

/* rtl/rvx_div.sv */
`default_nettype none

module rvx_div
    import rvx_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic                   done,
    output logic [DATA_W-1:0]      quotient,
    output logic [DATA_W-1:0]      remainder
);

    localparam int CW = $clog2(DATA_W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DATA_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_reg <= diff[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* rtl/rvx_checker.sv */
`default_nettype none

module rvx_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic               halted,
    input wire logic               wrote_reg,
    input wire logic [3:0]         write_index,
    input wire logic signed [31:0] write_value,
    input wire logic               div_by_zero
);

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !wrote_reg) |-> (write_index == 4'd0 && write_value == 32'sd0))
        else $error("result without a register write carries a nonzero index or value");

    a_dz_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && div_by_zero) |-> (wrote_reg && write_value == 32'sd0 && !halted))
        else $error("divide by zero result is not a zero register write");

    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && halted) |-> (!wrote_reg && !div_by_zero))
        else $error("halted result reports a register write or a divide flag");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("output transfer withdrawn while stalled");

endmodule

bind register_vm_execute_unit rvx_checker u_rvx_checker (.*);

`default_nettype wire
